/* hw/rtl/assert_macros.svh */
// Concurrent assertion helpers, clocked on clk and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies another at the same edge.
`define ASSERT_IMPLIES(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Check that a condition implies another at the next edge.
`define ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

/* hw/rtl/dq_pkg.sv */
package dq_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CAP_W = 7;
    localparam int WORD_W = 32;
    localparam int OP_W = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    localparam logic [OP_W-1:0] OP_QUERY      = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]          opcode;
        logic signed [WORD_W-1:0] value;
    } dq_op_t;

    typedef struct packed {
        logic                     ok;
        logic signed [WORD_W-1:0] front_value;
        logic signed [WORD_W-1:0] rear_value;
        logic                     is_empty;
        logic                     is_full;
        logic [6:0]               entry_count;
    } dq_res_t;

endpackage

/* hw/rtl/circular_deque.sv */
// Double-ended queue of signed 32-bit words held in a ring with a
// programmable capacity.
// Channels: op carries one request (opcode, value) on op_valid/op_ready;
// res returns one result per request on res_valid/res_ready; cfg_capacity
// is written on cfg_valid/cfg_ready, only while no request is in flight.
// A capacity of 0 acts as 1 and a value above the ring depth acts as the
// depth. Every capacity write also empties the deque.
// Flow: an accepted request is written back as it is taken in S_IDLE,
// the two ring memories that supply the front and rear words are read
// through a register in S_READ, and the result enters the output
// register in S_LOAD. A new request is taken only in S_IDLE, after the
// previous result has been loaded into the output register.
// Reset: the deque is empty and the capacity is 64; ring contents are
// undefined and are never shown, since only written entries are read.
// Stall: a result waits in the output register while res_ready is low;
// the block accepts one more request meanwhile and holds it until the
// output register is free.
module circular_deque (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            op_valid,
    output logic            op_ready,
    input  dq_pkg::dq_op_t  op,
    output logic            res_valid,
    input  logic            res_ready,
    output dq_pkg::dq_res_t res,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [6:0]      cfg_capacity
);

    import dq_pkg::*;

    `include "assert_macros.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [IDX_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CAP_W-1:0]   cap_reg;
    logic               ok_reg, ok_next;
    dq_res_t            res_reg, res_next;
    logic               res_valid_reg, res_valid_next;

    logic [CNT_W-1:0]   eff_cap;
    logic               op_fire;
    logic               cfg_fire;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [WORD_W-1:0]  front_word;
    logic [WORD_W-1:0]  rear_word;
    logic               load_res;

    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (32'(cap_reg) > 32'(DEPTH))
        begin
            eff_cap = CNT_W'(DEPTH);
        end
        else
        begin
            eff_cap = CNT_W'(cap_reg);
        end
    end

    assign cfg_ready = (state_reg == S_IDLE);
    assign op_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign op_fire   = op_valid && op_ready;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        ok_next    = ok_reg;
        wr_en      = 1'b0;
        wr_addr    = head_reg;
        if (op_fire)
        begin
            ok_next = 1'b0;
            case (op.opcode)
                OP_QUERY:
                begin
                    ok_next = 1'b1;
                end
                OP_PUSH_FRONT:
                begin
                    if (count_reg < eff_cap)
                    begin
                        if (count_reg == '0)
                        begin
                            head_next = '0;
                            tail_next = '0;
                        end
                        else if (head_reg == '0)
                        begin
                            head_next = IDX_W'(eff_cap - CNT_W'(1));
                        end
                        else
                        begin
                            head_next = head_reg - IDX_W'(1);
                        end
                        wr_en      = 1'b1;
                        wr_addr    = head_next;
                        count_next = count_reg + CNT_W'(1);
                        ok_next    = 1'b1;
                    end
                end
                OP_PUSH_REAR:
                begin
                    if (count_reg < eff_cap)
                    begin
                        if (count_reg == '0)
                        begin
                            head_next = '0;
                            tail_next = '0;
                        end
                        else if (CNT_W'(tail_reg) + CNT_W'(1) >= eff_cap)
                        begin
                            tail_next = '0;
                        end
                        else
                        begin
                            tail_next = tail_reg + IDX_W'(1);
                        end
                        wr_en      = 1'b1;
                        wr_addr    = tail_next;
                        count_next = count_reg + CNT_W'(1);
                        ok_next    = 1'b1;
                    end
                end
                OP_POP_FRONT:
                begin
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        if (count_reg == CNT_W'(1))
                        begin
                            head_next = '0;
                            tail_next = '0;
                        end
                        else if (CNT_W'(head_reg) + CNT_W'(1) >= eff_cap)
                        begin
                            head_next = '0;
                        end
                        else
                        begin
                            head_next = head_reg + IDX_W'(1);
                        end
                        ok_next = 1'b1;
                    end
                end
                OP_POP_REAR:
                begin
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        if (count_reg == CNT_W'(1))
                        begin
                            head_next = '0;
                            tail_next = '0;
                        end
                        else if (tail_reg == '0)
                        begin
                            tail_next = IDX_W'(eff_cap - CNT_W'(1));
                        end
                        else
                        begin
                            tail_next = tail_reg - IDX_W'(1);
                        end
                        ok_next = 1'b1;
                    end
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    dq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_front_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (op.value),
        .rd_addr (head_reg),
        .rd_data (front_word)
    );

    dq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_rear_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (op.value),
        .rd_addr (tail_reg),
        .rd_data (rear_word)
    );

    assign load_res = (state_reg == S_LOAD) && (!res_valid_reg || res_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (op_fire)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (load_res)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_ready;
        if (load_res)
        begin
            res_next.ok          = ok_reg;
            res_next.is_empty    = (count_reg == '0);
            res_next.is_full     = (count_reg == eff_cap);
            res_next.entry_count = 7'(count_reg);
            res_next.front_value = (count_reg == '0) ? '1 : front_word;
            res_next.rear_value  = (count_reg == '0) ? '1 : rear_word;
            res_valid_next       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            ok_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ok_reg        <= ok_next;
            res_valid_reg <= res_valid_next;
            if (cfg_fire)
            begin
                cap_reg   <= cfg_capacity;
                head_reg  <= '0;
                tail_reg  <= '0;
                count_reg <= '0;
            end
            else
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `ASSERT_ALWAYS(a_count_in_cap, count_reg <= eff_cap, "count above capacity")
    `ASSERT_IMPLIES(a_empty_at_origin, count_reg == '0, (head_reg == '0) && (tail_reg == '0), "empty deque with nonzero index")
    `ASSERT_NEXT(a_accept_to_read, op_fire, (state_reg == S_READ) && !op_ready, "request not followed by read")
    `ASSERT_NEXT(a_read_to_load, state_reg == S_READ, state_reg == S_LOAD, "read not followed by load")

endmodule

/* hw/rtl/dq_ram.sv */
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* sim/dq_checker.sv */
`timescale 1ns / 1ps

module dq_checker (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     op_valid,
    input  logic                     op_ready,
    input  dq_pkg::dq_op_t           op,
    input  logic                     res_valid,
    input  logic                     res_ready,
    input  dq_pkg::dq_res_t          res,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [dq_pkg::CAP_W-1:0] cfg_capacity,
    output int                       mismatches,
    output int                       outstanding
);

    import dq_pkg::*;

    logic [WORD_W-1:0] ring_words [DEPTH];
    int                front_pos;
    int                rear_pos;
    int                held;
    logic [CAP_W-1:0]  capacity_reg;
    dq_res_t           expected_results [$];

    function automatic int usable_capacity();
        if (capacity_reg == 0)
            return 1;
        if (capacity_reg > DEPTH)
            return DEPTH;
        return int'(capacity_reg);
    endfunction

    function automatic dq_res_t apply_deque_op(dq_op_t item);
        int      cap;
        dq_res_t r;
        cap = usable_capacity();
        r = '0;
        case (item.opcode)
            OP_QUERY:
                r.ok = 1'b1;
            OP_PUSH_FRONT, OP_PUSH_REAR:
                if (held < cap)
                begin
                    if (held == 0)
                    begin
                        front_pos = 0;
                        rear_pos = 0;
                    end
                    else if (item.opcode == OP_PUSH_FRONT)
                        front_pos = (front_pos == 0) ? cap - 1 : front_pos - 1;
                    else
                        rear_pos = (rear_pos + 1 >= cap) ? 0 : rear_pos + 1;
                    if (item.opcode == OP_PUSH_FRONT)
                        ring_words[front_pos] = item.value;
                    else
                        ring_words[rear_pos] = item.value;
                    held++;
                    r.ok = 1'b1;
                end
            OP_POP_FRONT, OP_POP_REAR:
                if (held > 0)
                begin
                    held--;
                    if (held == 0)
                    begin
                        front_pos = 0;
                        rear_pos = 0;
                    end
                    else if (item.opcode == OP_POP_FRONT)
                        front_pos = (front_pos + 1 >= cap) ? 0 : front_pos + 1;
                    else
                        rear_pos = (rear_pos == 0) ? cap - 1 : rear_pos - 1;
                    r.ok = 1'b1;
                end
            default:
                r.ok = 1'b0;
        endcase
        r.front_value = (held == 0) ? '1 : ring_words[front_pos];
        r.rear_value = (held == 0) ? '1 : ring_words[rear_pos];
        r.is_empty = (held == 0);
        r.is_full = (held == cap);
        r.entry_count = 7'(held);
        return r;
    endfunction

    task automatic check_field(string name, logic [WORD_W-1:0] want,
                               logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        dq_res_t want;
        if (!rst_n)
        begin
            front_pos = 0;
            rear_pos = 0;
            held = 0;
            capacity_reg = CAP_RESET;
            expected_results.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg = cfg_capacity;
                front_pos = 0;
                rear_pos = 0;
                held = 0;
            end
            if (res_valid && res_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: unrequested result, expected none, actual %h",
                             $time, res);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("ok", want.ok, res.ok);
                    check_field("front_value", want.front_value, res.front_value);
                    check_field("rear_value", want.rear_value, res.rear_value);
                    check_field("is_empty", want.is_empty, res.is_empty);
                    check_field("is_full", want.is_full, res.is_full);
                    check_field("entry_count", want.entry_count, res.entry_count);
                end
            end
            if (op_valid && op_ready)
                expected_results.push_back(apply_deque_op(op));
            outstanding = expected_results.size();
        end
    end

endmodule

/* sim/circular_deque_test.sv */
`timescale 1ns / 1ps

module circular_deque_test;
    import dq_pkg::*;

    localparam logic [OP_W-1:0] OP_BAD_FIRST = OP_POP_REAR + 1'b1;
    localparam logic [OP_W-1:0] OP_BAD_LAST  = '1;
    localparam int              PHASES       = 11;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             op_valid;
    logic             op_ready;
    dq_op_t           op;
    logic             res_valid;
    logic             res_ready = 1'b0;
    dq_res_t          res;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_capacity;
    int               mismatches;
    int               outstanding;
    int               burst_left = 0;
    int               recv_mode = 0;
    int               recv_left = 0;

    circular_deque i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .op_valid     (op_valid),
        .op_ready     (op_ready),
        .op           (op),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_capacity (cfg_capacity)
    );

    dq_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .op_valid     (op_valid),
        .op_ready     (op_ready),
        .op           (op),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_capacity (cfg_capacity),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // receiver: alternate between always ready, coin flip and long stalls
    always @(negedge clk)
    begin
        if (recv_left == 0)
        begin
            recv_mode <= $urandom_range(0, 2);
            recv_left <= $urandom_range(16, 96);
        end
        else
            recv_left <= recv_left - 1;
        case (recv_mode)
            0: res_ready <= 1'b1;
            1: res_ready <= 1'($urandom_range(0, 1));
            default: res_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '1;
            3: return '0;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [CAP_W-1:0] phase_capacity(int p);
        case (p)
            0: return 7'd64;
            1: return 7'd1;
            2: return 7'd2;
            3: return 7'd3;
            4: return 7'd0;
            5: return 7'd7;
            6: return 7'd127;
            7: return 7'd100;
            8: return 7'd16;
            9: return 7'd5;
            default: return 7'd64;
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic issue_op(logic [OP_W-1:0] code, logic [WORD_W-1:0] word);
        op_valid <= 1'b1;
        op.opcode <= code;
        op.value <= word;
        do
            @(posedge clk);
        while (!op_ready);
        @(negedge clk);
    endtask

    task automatic sender_gap(int cycles);
        op_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic wait_drained();
        op_valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] cap);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_capacity <= cap;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_op(int push_pct);
        logic [OP_W-1:0] code;
        int              roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            code = OP_QUERY;
        else if (roll < 6)
            code = OP_W'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
        else if ($urandom_range(0, 99) < push_pct)
            code = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
        else
            code = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
        issue_op(code, pick_word());
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            sender_gap($urandom_range(1, 8));
        end
        else
            burst_left--;
    endtask

    initial
    begin
        int               span;
        logic [CAP_W-1:0] cap;
        rst_n = 1'b0;
        op_valid = 1'b0;
        op = '0;
        cfg_valid = 1'b0;
        cfg_capacity = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        issue_op(OP_QUERY, '0);
        issue_op(OP_POP_FRONT, '0);
        issue_op(OP_POP_REAR, '1);
        issue_op(OP_BAD_FIRST, 32'h1234_5678);
        issue_op(OP_PUSH_FRONT, 32'h7FFF_FFFF);
        issue_op(OP_PUSH_REAR, 32'h8000_0000);
        issue_op(OP_PUSH_FRONT, '1);
        issue_op(OP_PUSH_REAR, '0);
        issue_op(OP_QUERY, '1);
        issue_op(OP_POP_FRONT, '0);
        issue_op(OP_POP_REAR, '0);
        issue_op(OP_POP_FRONT, '0);
        issue_op(OP_POP_REAR, '0);
        issue_op(OP_PUSH_REAR, 32'h1234_5678);
        issue_op(OP_BAD_FIRST + 1'b1, '0);
        issue_op(OP_BAD_LAST, '1);
        issue_op(OP_POP_FRONT, '0);

        set_capacity(7'd1);
        issue_op(OP_PUSH_REAR, 32'hA5A5_A5A5);
        issue_op(OP_PUSH_FRONT, 32'h5A5A_5A5A);
        issue_op(OP_POP_REAR, '0);
        issue_op(OP_POP_FRONT, '0);
        set_capacity(7'd0);
        issue_op(OP_PUSH_FRONT, 32'h5A5A_5A5A);
        issue_op(OP_PUSH_REAR, 32'hA5A5_A5A5);
        set_capacity(7'd127);
        issue_op(OP_PUSH_FRONT, 32'h0000_0001);
        issue_op(OP_QUERY, '0);

        for (int p = 0; p < PHASES; p++)
        begin
            cap = phase_capacity(p);
            span = (cap >= DEPTH) ? 130 : 75;
            set_capacity(cap);
            for (int i = 0; i < span; i++)
            begin
                if (p == 2 && i == span / 2)
                    wait_drained();
                if (i < span * 2 / 3)
                    random_op((cap > 32) ? 95 : 65);
                else
                    random_op(30);
            end
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* circular_deque.f */
+incdir+hw/rtl
hw/rtl/dq_pkg.sv
hw/rtl/dq_ram.sv
hw/rtl/circular_deque.sv
sim/dq_checker.sv
sim/circular_deque_test.sv
